/* design/eulrot_pkg.sv */
// Shared types, constants and arithmetic helpers for the Euler angle to rotation matrix block.
// No dependencies; every other design file imports this package.
package eulrot_pkg;

    localparam int ANGLE_BITS = 16;
    localparam int FRAC_BITS  = 14;
    localparam int OUT_BITS   = FRAC_BITS + 2;
    localparam int ITERS      = 31;
    localparam int Q_DEPTH    = 4;
    localparam int TRIG_BITS  = 32;
    localparam int CW         = 34;

    localparam logic signed [CW-1:0] CORDIC_K = 34'sd652032874;
    localparam logic signed [CW-1:0] QUARTER  = 34'sd1073741824;
    localparam logic signed [CW-1:0] HALF     = 34'sd2147483648;
    localparam logic signed [CW-1:0] ONE_Q30  = 34'sd1073741824;

    localparam logic [2:0] ADDR_ORDER = 3'd0;

    typedef struct packed {
        logic signed [ANGLE_BITS-1:0] roll_angle;
        logic signed [ANGLE_BITS-1:0] pitch_angle;
        logic signed [ANGLE_BITS-1:0] yaw_angle;
    } t_in;

    typedef struct packed {
        logic signed [OUT_BITS-1:0] m00;
        logic signed [OUT_BITS-1:0] m01;
        logic signed [OUT_BITS-1:0] m02;
        logic signed [OUT_BITS-1:0] m10;
        logic signed [OUT_BITS-1:0] m11;
        logic signed [OUT_BITS-1:0] m12;
        logic signed [OUT_BITS-1:0] m20;
        logic signed [OUT_BITS-1:0] m21;
        logic signed [OUT_BITS-1:0] m22;
    } t_out;

    // sines and cosines of the three angles, Q2.30
    typedef struct packed {
        logic signed [TRIG_BITS-1:0] sr;
        logic signed [TRIG_BITS-1:0] cr;
        logic signed [TRIG_BITS-1:0] sp;
        logic signed [TRIG_BITS-1:0] cp;
        logic signed [TRIG_BITS-1:0] sy;
        logic signed [TRIG_BITS-1:0] cy;
    } t_trig;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
        logic                 neg;
    } t_cst;

    function automatic logic signed [CW-1:0] atan_tab(input int i);
        logic signed [CW-1:0] v;
        case (i)
            0:  v = 34'sh20000000;
            1:  v = 34'sh12E4051E;
            2:  v = 34'sh09FB385B;
            3:  v = 34'sh051111D4;
            4:  v = 34'sh028B0D43;
            5:  v = 34'sh0145D7E1;
            6:  v = 34'sh00A2F61E;
            7:  v = 34'sh00517C55;
            8:  v = 34'sh0028BE53;
            9:  v = 34'sh00145F2F;
            10: v = 34'sh000A2F98;
            11: v = 34'sh000517CC;
            12: v = 34'sh00028BE6;
            13: v = 34'sh000145F3;
            14: v = 34'sh0000A2F9;
            15: v = 34'sh0000517C;
            16: v = 34'sh000028BE;
            17: v = 34'sh0000145F;
            18: v = 34'sh00000A2F;
            19: v = 34'sh00000517;
            20: v = 34'sh0000028B;
            21: v = 34'sh00000145;
            22: v = 34'sh000000A2;
            23: v = 34'sh00000051;
            24: v = 34'sh00000028;
            25: v = 34'sh00000014;
            26: v = 34'sh0000000A;
            27: v = 34'sh00000005;
            28: v = 34'sh00000002;
            29: v = 34'sh00000001;
            default: v = '0;
        endcase
        return v;
    endfunction

    // Q2.30 product, rounded half up
    function automatic logic signed [TRIG_BITS-1:0] mul(
        input logic signed [TRIG_BITS-1:0] a,
        input logic signed [TRIG_BITS-1:0] b
    );
        logic signed [63:0] p;
        p = 64'(a) * 64'(b) + 64'sd536870912;
        return p[61:30];
    endfunction

endpackage

/* design/eulrot_front.sv */
// Front end: takes angle transfers and runs three pipelined CORDIC rotators.
// Depends on eulrot_pkg.
module eulrot_front import eulrot_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_in   i_data,
    output logic  o_valid,
    input  logic  i_ready,
    output t_trig o_trig
);

    logic             w_adv;
    logic [ITERS:0]   r_vld;
    t_cst             r_st [0:ITERS][3];
    logic signed [ANGLE_BITS-1:0] w_ang [3];
    logic signed [TRIG_BITS-1:0]  w_sin [3];
    logic signed [TRIG_BITS-1:0]  w_cos [3];

    function automatic t_cst reduce(input logic signed [ANGLE_BITS-1:0] a);
        t_cst c;
        logic signed [CW-1:0] z;
        z = CW'($signed({a, {(32-ANGLE_BITS){1'b0}}}));
        c.x = CORDIC_K;
        c.y = '0;
        c.neg = 1'b0;
        if (z > QUARTER) begin
            z = z - HALF;
            c.neg = 1'b1;
        end else if (z < -QUARTER) begin
            z = z + HALF;
            c.neg = 1'b1;
        end
        c.z = z;
        return c;
    endfunction

    function automatic t_cst step(input t_cst c, input int i);
        t_cst n;
        n.neg = c.neg;
        if (!c.z[CW-1]) begin
            n.x = c.x - (c.y >>> i);
            n.y = c.y + (c.x >>> i);
            n.z = c.z - atan_tab(i);
        end else begin
            n.x = c.x + (c.y >>> i);
            n.y = c.y - (c.x >>> i);
            n.z = c.z + atan_tab(i);
        end
        return n;
    endfunction

    function automatic logic signed [TRIG_BITS-1:0] clamp(
        input logic signed [CW-1:0] v,
        input logic                 neg
    );
        logic signed [CW-1:0] t;
        t = neg ? -v : v;
        if (t > ONE_Q30) t = ONE_Q30;
        if (t < -ONE_Q30) t = -ONE_Q30;
        return t[TRIG_BITS-1:0];
    endfunction

    // advance the whole pipe unless the last stage is blocked by a full queue
    assign w_adv   = !r_vld[ITERS] || i_ready;
    assign o_ready = w_adv;
    assign o_valid = r_vld[ITERS];

    assign w_ang[0] = i_data.roll_angle;
    assign w_ang[1] = i_data.pitch_angle;
    assign w_ang[2] = i_data.yaw_angle;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[ITERS-1:0], i_valid};
        end
    end

    for (genvar a = 0; a < 3; a++) begin : g_ang
        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_st[0][a] <= reduce(w_ang[a]);
            end
        end
        for (genvar s = 0; s < ITERS; s++) begin : g_stage
            always_ff @(posedge i_clk) begin
                if (w_adv) begin
                    r_st[s+1][a] <= step(r_st[s][a], s);
                end
            end
        end
        assign w_sin[a] = clamp(r_st[ITERS][a].y, r_st[ITERS][a].neg);
        assign w_cos[a] = clamp(r_st[ITERS][a].x, r_st[ITERS][a].neg);
    end

    assign o_trig.sr = w_sin[0];
    assign o_trig.cr = w_cos[0];
    assign o_trig.sp = w_sin[1];
    assign o_trig.cp = w_cos[1];
    assign o_trig.sy = w_sin[2];
    assign o_trig.cy = w_cos[2];

endmodule

/* design/eulrot_fifo.sv */
// Short queue of sine/cosine sets between the front end and the matrix back end.
// Depends on eulrot_pkg.
module eulrot_fifo import eulrot_pkg::*; #(
    parameter int DEPTH = Q_DEPTH
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_trig i_data,
    output logic  o_valid,
    input  logic  i_ready,
    output t_trig o_data
);

    localparam int PW = $clog2(DEPTH);
    localparam int CNW = $clog2(DEPTH + 1);

    t_trig          r_mem [DEPTH];
    logic [PW-1:0]  r_wr, r_rd;
    logic [CNW-1:0] r_cnt;
    logic           w_push, w_pop;

    assign o_ready = (r_cnt != CNW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            r_cnt <= r_cnt + CNW'(w_push) - CNW'(w_pop);
        end
    end

endmodule

/* design/eulrot_back.sv */
// Back end: multiplies the elementary rotations into the nine matrix entries.
// Depends on eulrot_pkg.
module eulrot_back import eulrot_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_order,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_trig i_trig,
    output logic  o_valid,
    input  logic  i_ready,
    output t_out  o_data
);

    localparam int SW = TRIG_BITS + 1;

    typedef logic signed [TRIG_BITS-1:0] t_q;

    logic  w_adv;
    logic  r_vld_a, r_vld_b, r_vld_o;
    t_trig r_t_a, r_t_b;
    // two-factor products
    t_q r_cpcy, r_cpsy, r_crsy, r_srsp, r_crcy, r_srcp;
    t_q r_srsy, r_crsp, r_srcy, r_crcp, r_cysp, r_sysp;
    t_q r_b_cpcy, r_b_cpsy, r_b_crsy, r_b_crcy, r_b_srcp;
    t_q r_b_srsy, r_b_srcy, r_b_crcp;
    t_q r_b0, r_b1, r_b2, r_b3;
    t_q w_p, w_q, w_u, w_v;
    logic signed [SW-1:0] w_m [9];
    t_out r_out;

    function automatic logic signed [SW-1:0] ext(input t_q v);
        return SW'(v);
    endfunction

    function automatic logic signed [OUT_BITS-1:0] to_out(input logic signed [SW-1:0] v);
        logic signed [SW:0] t;
        logic signed [SW:0] lim;
        t = (SW+1)'(v) + (SW+1)'(1 << (29 - FRAC_BITS));
        t = t >>> (30 - FRAC_BITS);
        lim = (SW+1)'(1) <<< FRAC_BITS;
        if (t > lim) t = lim;
        if (t < -lim) t = -lim;
        return t[OUT_BITS-1:0];
    endfunction

    assign w_adv   = !r_vld_o || i_ready;
    assign o_ready = w_adv;
    assign o_valid = r_vld_o;
    assign o_data  = r_out;

    // operands of the three-factor products, chosen by rotation order
    assign w_p = i_order ? r_cysp : r_srsp;
    assign w_q = i_order ? r_sysp : r_crsp;
    assign w_u = i_order ? r_t_a.sr : r_t_a.cy;
    assign w_v = i_order ? r_t_a.cr : r_t_a.sy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a <= 1'b0;
            r_vld_b <= 1'b0;
            r_vld_o <= 1'b0;
        end else if (w_adv) begin
            r_vld_a <= i_valid;
            r_vld_b <= r_vld_a;
            r_vld_o <= r_vld_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_t_a  <= i_trig;
            r_cpcy <= mul(i_trig.cp, i_trig.cy);
            r_cpsy <= mul(i_trig.cp, i_trig.sy);
            r_crsy <= mul(i_trig.cr, i_trig.sy);
            r_srsp <= mul(i_trig.sr, i_trig.sp);
            r_crcy <= mul(i_trig.cr, i_trig.cy);
            r_srcp <= mul(i_trig.sr, i_trig.cp);
            r_srsy <= mul(i_trig.sr, i_trig.sy);
            r_crsp <= mul(i_trig.cr, i_trig.sp);
            r_srcy <= mul(i_trig.sr, i_trig.cy);
            r_crcp <= mul(i_trig.cr, i_trig.cp);
            r_cysp <= mul(i_trig.cy, i_trig.sp);
            r_sysp <= mul(i_trig.sy, i_trig.sp);

            r_t_b    <= r_t_a;
            r_b_cpcy <= r_cpcy;
            r_b_cpsy <= r_cpsy;
            r_b_crsy <= r_crsy;
            r_b_crcy <= r_crcy;
            r_b_srcp <= r_srcp;
            r_b_srsy <= r_srsy;
            r_b_srcy <= r_srcy;
            r_b_crcp <= r_crcp;
            r_b0 <= mul(w_p, w_u);
            r_b1 <= mul(w_p, w_v);
            r_b2 <= mul(w_q, w_u);
            r_b3 <= mul(w_q, w_v);

            r_out.m00 <= to_out(w_m[0]);
            r_out.m01 <= to_out(w_m[1]);
            r_out.m02 <= to_out(w_m[2]);
            r_out.m10 <= to_out(w_m[3]);
            r_out.m11 <= to_out(w_m[4]);
            r_out.m12 <= to_out(w_m[5]);
            r_out.m20 <= to_out(w_m[6]);
            r_out.m21 <= to_out(w_m[7]);
            r_out.m22 <= to_out(w_m[8]);
        end
    end

    always_comb begin
        if (!i_order) begin
            w_m[0] = ext(r_b_cpcy);
            w_m[1] = -ext(r_b_cpsy);
            w_m[2] = ext(r_t_b.sp);
            w_m[3] = ext(r_b_crsy) + ext(r_b0);
            w_m[4] = ext(r_b_crcy) - ext(r_b1);
            w_m[5] = -ext(r_b_srcp);
            w_m[6] = ext(r_b_srsy) - ext(r_b2);
            w_m[7] = ext(r_b_srcy) + ext(r_b3);
            w_m[8] = ext(r_b_crcp);
        end else begin
            w_m[0] = ext(r_b_cpcy);
            w_m[1] = ext(r_b0) - ext(r_b_crsy);
            w_m[2] = ext(r_b1) + ext(r_b_srsy);
            w_m[3] = ext(r_b_cpsy);
            w_m[4] = ext(r_b2) + ext(r_b_crcy);
            w_m[5] = ext(r_b3) - ext(r_b_srcy);
            w_m[6] = -ext(r_t_b.sp);
            w_m[7] = ext(r_b_srcp);
            w_m[8] = ext(r_b_crcp);
        end
    end

endmodule

/* design/euler_to_rotation_matrix.sv */
// Euler angles (roll, pitch, yaw) to 3x3 rotation matrix, top level.
// Depends on eulrot_pkg, eulrot_front, eulrot_fifo and eulrot_back.
//
// Each input transfer carries three signed binary angles (full range = one turn)
// and yields one output transfer of nine Q2.14 entries in row-major order,
// saturated to plus or minus one. The rotation_order register (byte address 0,
// bit 0) selects Rx*Ry*Rz when 0 (reset) and Rz*Ry*Rx when 1; write it only while
// the block is idle. The block takes one transfer every cycle unless a stall
// at the output has filled the queue. The edge that accepts the input loads the
// angle range reduction register, then come 31 CORDIC stages (one iteration per
// stage, three rotators side by side), the queue, and in the back end one stage
// of two-factor products, one of three-factor products and the output register
// after summing and rounding. A four-entry queue between the CORDIC pipe and
// the multiplier pipe lets each side stall on its own; a stall at the output
// holds the multiplier pipe, and the CORDIC pipe carries on until the queue
// fills.
module euler_to_rotation_matrix import eulrot_pkg::*; #(
    parameter int QUEUE_DEPTH = Q_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_in         i_data,
    output logic        o_valid,
    input  logic        i_ready,
    output t_out        o_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic  r_order;
    logic  w_f_vld, w_f_rdy, w_q_vld, w_q_rdy;
    t_trig w_f_trig, w_q_trig;

    // configuration: always ready, write on the access phase
    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_ORDER) ? {31'b0, r_order} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order <= 1'b0;
        end else if (psel && penable && pwrite && paddr[2] == 1'b0) begin
            r_order <= pwdata[0];
        end
    end

    eulrot_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (w_f_vld),
        .i_ready (w_f_rdy),
        .o_trig  (w_f_trig)
    );

    eulrot_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_f_vld),
        .o_ready (w_f_rdy),
        .i_data  (w_f_trig),
        .o_valid (w_q_vld),
        .i_ready (w_q_rdy),
        .o_data  (w_q_trig)
    );

    eulrot_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_order (r_order),
        .i_valid (w_q_vld),
        .o_ready (w_q_rdy),
        .i_trig  (w_q_trig),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

`ifndef SYNTHESIS
    // hold the CORDIC output while the queue refuses it
    a_front_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_f_vld && !w_f_rdy |=> w_f_vld)
        else $error("front end dropped a sine/cosine set");

    // entries m00 and m22 stay within plus or minus one
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_data.m00 <= 16'sd16384) && (o_data.m00 >= -16'sd16384)
                 && (o_data.m22 <= 16'sd16384) && (o_data.m22 >= -16'sd16384))
        else $error("matrix entry out of range");

    // nothing leaves the back end straight after reset
    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("output valid after reset");
`endif

endmodule
